>>> hdl/pad_pkg.sv
// Shared constants and types for the projectile acceleration block.
package pad_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MAG_W     = 62;

  // Clip bound for intermediate magnitudes (2^61)
  localparam logic [63:0] LIM    = 64'd1 << 61;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] G_Q30  = 64'd10533093295;

  typedef logic [MAG_W-1:0] mag_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BODY_MASS,
    CFG_BODY_RADIUS,
    CFG_AIR_DENSITY,
    CFG_DRAG_COEFF,
    CFG_MAGNUS_COEFF,
    CFG_SPIN_X,
    CFG_SPIN_Y,
    CFG_SPIN_Z
  } cfg_idx_t;

endpackage

>>> hdl/pad_if.sv
// Channel interfaces: velocity input, acceleration output, register writes.
interface pad_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pad_pkg::DATA_W-1:0]  vel_x;
  logic signed [pad_pkg::DATA_W-1:0]  vel_y;
  logic signed [pad_pkg::DATA_W-1:0]  vel_z;
  logic signed [pad_pkg::DATA_W-1:0]  wind_x;
  logic signed [pad_pkg::DATA_W-1:0]  wind_y;
  logic signed [pad_pkg::DATA_W-1:0]  wind_z;
  modport source (output valid, vel_x, vel_y, vel_z, wind_x, wind_y, wind_z, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, wind_x, wind_y, wind_z, output ready);
endinterface

interface pad_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pad_pkg::DATA_W-1:0]  acc_x;
  logic signed [pad_pkg::DATA_W-1:0]  acc_y;
  logic signed [pad_pkg::DATA_W-1:0]  acc_z;
  logic                               saturated;
  modport source (output valid, acc_x, acc_y, acc_z, saturated, input ready);
  modport sink   (input valid, acc_x, acc_y, acc_z, saturated, output ready);
endinterface

interface pad_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pad_pkg::CFG_IDX_W-1:0]    index;
  logic [pad_pkg::DATA_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/pad_dly.sv
// Enabled delay line for pipeline side data.
module pad_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

>>> hdl/pad_mulq.sv
// Three-stage unsigned fixed-point multiply, truncate and clip to 2^61.
module pad_mulq #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output pad_pkg::mag_t p,
  output logic          clip
);

  logic [63:0]   ll_r, lh_r, hl_r, hh_r;
  logic [127:0]  prod_r;
  logic [127:0]  shd;
  logic          ovf;
  pad_pkg::mag_t p_r;
  logic          clip_r;

  // 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= 64'(a[31:0])  * 64'(b[31:0]);
      lh_r <= 64'(a[31:0])  * 64'(b[63:32]);
      hl_r <= 64'(a[63:32]) * 64'(b[31:0]);
      hh_r <= 64'(a[63:32]) * 64'(b[63:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {64'd0, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + {hh_r, 64'd0};
    end
  end

  assign shd = prod_r >> FRAC_BITS;
  assign ovf = shd > {64'd0, pad_pkg::LIM};

  always_ff @(posedge clk) begin
    if (en) begin
      clip_r <= ovf;
      p_r    <= ovf ? pad_pkg::LIM[pad_pkg::MAG_W-1:0] : shd[pad_pkg::MAG_W-1:0];
    end
  end

  assign p    = p_r;
  assign clip = clip_r;

endmodule

>>> hdl/pad_sqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage.
module pad_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_in,
  output logic [31:0] root
);

  logic [63:0] n_r   [1:31];
  logic [63:0] res_r [1:32];

  for (genvar j = 0; j < 32; j++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] n_cur, res_cur, t, n_nxt, res_nxt;

    if (j == 0) begin : g_first
      assign n_cur   = n_in;
      assign res_cur = '0;
    end else begin : g_mid
      assign n_cur   = n_r[j];
      assign res_cur = res_r[j];
    end

    always_comb begin
      t = res_cur + BIT;
      if (n_cur >= t) begin
        n_nxt   = n_cur - t;
        res_nxt = (res_cur >> 1) + BIT;
      end else begin
        n_nxt   = n_cur;
        res_nxt = res_cur >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[j+1] <= res_nxt;
      end
    end

    if (j < 31) begin : g_n
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[j+1] <= n_nxt;
        end
      end
    end
  end

  assign root = res_r[32][31:0];

endmodule

>>> hdl/pad_div.sv
// Pipelined restoring divide, 32 quotient bits, two per stage.
module pad_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [30:0] den,
  output logic [31:0] quo
);

  logic [30:0] rem_r [1:15];
  logic [31:0] lo_r  [1:15];
  logic [31:0] q_r   [1:16];

  for (genvar j = 0; j < 16; j++) begin : g_st
    logic [30:0] rem_cur, r1, r2;
    logic [31:0] lo_cur, q_cur, t1, t2;
    logic        ge1, ge2;

    if (j == 0) begin : g_first
      assign rem_cur = num[62:32];
      assign lo_cur  = num[31:0];
      assign q_cur   = '0;
    end else begin : g_mid
      assign rem_cur = rem_r[j];
      assign lo_cur  = lo_r[j];
      assign q_cur   = q_r[j];
    end

    always_comb begin
      t1  = {rem_cur, lo_cur[31]};
      ge1 = t1 >= {1'b0, den};
      r1  = ge1 ? 31'(t1 - {1'b0, den}) : t1[30:0];
      t2  = {r1, lo_cur[30]};
      ge2 = t2 >= {1'b0, den};
      r2  = ge2 ? 31'(t2 - {1'b0, den}) : t2[30:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j+1] <= {q_cur[29:0], ge1, ge2};
      end
    end

    if (j < 15) begin : g_lo
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= r2;
          lo_r[j+1]  <= {lo_cur[29:0], 2'b00};
        end
      end
    end
  end

  assign quo = q_r[16];

endmodule

>>> hdl/projectile_accel_drag_magnus.sv
// Projectile acceleration from gravity, drag and Magnus force (top level).
//
// One item per cycle in while the pipeline is not stalled, one result per item
// out. Relative velocity r = vel - wind; speed |r| comes from a 32-stage
// integer square root, drag = -k*|r|*r with k = rho*Cd*pi*radius^2/2,
// Magnus = S*(spin x r), gravity = -mass*g on z. The force sum is divided by
// mass in a 16-stage restoring divider (two quotient bits per stage) per axis.
// Every fixed-point product but the squares for the speed runs through a
// three-stage 32x32 partial-product multiplier. The whole pipeline shares one
// enable: it advances whenever the output register is empty or being taken,
// so in_ch.ready drops only while a result waits at the output or during
// reset. cfg_ch.ready is high whenever reset is released, but registers
// should only be changed while no item is in flight; the register-only terms
// (area, k, gravity) are computed from them by free-running multipliers.
// saturated flags any clip of an intermediate or of the final value.
module projectile_accel_drag_magnus #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  pad_in_if.sink           in_ch,
  pad_out_if.source        out_ch,
  pad_cfg_if.sink          cfg_ch
);

  localparam int LAT = 60;
  localparam logic [63:0] PI_Q =
    (pad_pkg::PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam logic [63:0] G_Q =
    (pad_pkg::G_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam logic signed [63:0] LIM_S = signed'(pad_pkg::LIM);

  // cross product operand picks: cr_i = sp[A]*r[B] - sp[C]*r[D]
  localparam int CA_S [3] = '{1, 2, 0};
  localparam int CA_R [3] = '{2, 0, 1};
  localparam int CB_S [3] = '{2, 0, 1};
  localparam int CB_R [3] = '{1, 2, 0};

  function automatic logic signed [63:0] smag(input pad_pkg::mag_t m, input logic neg);
    logic signed [63:0] v;
    v = signed'({2'b00, m});
    return neg ? -v : v;
  endfunction

  function automatic logic ovr(input logic signed [63:0] x);
    return (x > LIM_S) || (x < -LIM_S);
  endfunction

  function automatic logic signed [63:0] clipv(input logic signed [63:0] x);
    logic signed [63:0] v;
    v = x;
    if (x > LIM_S) v = LIM_S;
    if (x < -LIM_S) v = -LIM_S;
    return v;
  endfunction

  function automatic pad_pkg::mag_t absm(input logic signed [63:0] x);
    logic signed [63:0] v;
    v = (x < 0) ? -x : x;
    return v[pad_pkg::MAG_W-1:0];
  endfunction

  // ---------------- configuration registers ----------------
  logic [30:0]        body_mass_r, body_radius_r, air_density_r, drag_coeff_r;
  logic signed [31:0] magnus_coeff_r;
  logic signed [31:0] spin_r [3];

  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_mass_r    <= 31'd65536;
      body_radius_r  <= 31'd6554;
      air_density_r  <= '0;
      drag_coeff_r   <= 31'd30802;
      magnus_coeff_r <= '0;
      spin_r[0]      <= '0;
      spin_r[1]      <= '0;
      spin_r[2]      <= '0;
    end else if (cfg_ch.valid) begin
      case (pad_pkg::cfg_idx_t'(cfg_ch.index))
        pad_pkg::CFG_BODY_MASS:    body_mass_r    <= cfg_ch.data[30:0];
        pad_pkg::CFG_BODY_RADIUS:  body_radius_r  <= cfg_ch.data[30:0];
        pad_pkg::CFG_AIR_DENSITY:  air_density_r  <= cfg_ch.data[30:0];
        pad_pkg::CFG_DRAG_COEFF:   drag_coeff_r   <= cfg_ch.data[30:0];
        pad_pkg::CFG_MAGNUS_COEFF: magnus_coeff_r <= signed'(cfg_ch.data);
        pad_pkg::CFG_SPIN_X:       spin_r[0]      <= signed'(cfg_ch.data);
        pad_pkg::CFG_SPIN_Y:       spin_r[1]      <= signed'(cfg_ch.data);
        pad_pkg::CFG_SPIN_Z:       spin_r[2]      <= signed'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // zero mass treated as one LSB
  logic [30:0] mass_eff;
  assign mass_eff = (body_mass_r == '0) ? 31'd1 : body_mass_r;

  // ---------------- register-only terms (free running) ----------------
  pad_pkg::mag_t t1_p, area_p, t2_p, k_p, grav_p;
  logic          t1_c, area_c, t2_c, k_c, grav_c;
  logic          static_fl;
  pad_pkg::mag_t k_half;

  pad_mulq #(.FRAC_BITS(FRAC_BITS)) u_t1 (
    .clk, .en(1'b1), .a(PI_Q), .b(64'(body_radius_r)), .p(t1_p), .clip(t1_c));
  pad_mulq #(.FRAC_BITS(FRAC_BITS)) u_area (
    .clk, .en(1'b1), .a(64'(t1_p)), .b(64'(body_radius_r)), .p(area_p), .clip(area_c));
  pad_mulq #(.FRAC_BITS(FRAC_BITS)) u_t2 (
    .clk, .en(1'b1), .a(64'(air_density_r)), .b(64'(drag_coeff_r)), .p(t2_p), .clip(t2_c));
  pad_mulq #(.FRAC_BITS(FRAC_BITS)) u_k (
    .clk, .en(1'b1), .a(64'(t2_p)), .b(64'(area_p)), .p(k_p), .clip(k_c));
  pad_mulq #(.FRAC_BITS(FRAC_BITS)) u_grav (
    .clk, .en(1'b1), .a(64'(mass_eff)), .b(G_Q), .p(grav_p), .clip(grav_c));

  assign k_half    = k_p >> 1;
  assign static_fl = t1_c | area_c | t2_c | k_c | grav_c;

  // ---------------- pipeline control ----------------
  logic           en, acc;
  logic [LAT-1:0] vld_r;

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en && rst_n;
  assign acc         = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], acc};
    end
  end

  // ---------------- t0: relative velocity ----------------
  logic signed [32:0] r_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= 33'(in_ch.vel_x) - 33'(in_ch.wind_x);
      r_r[1] <= 33'(in_ch.vel_y) - 33'(in_ch.wind_y);
      r_r[2] <= 33'(in_ch.vel_z) - 33'(in_ch.wind_z);
    end
  end

  logic [31:0] ar [3];
  logic [2:0]  rneg;
  logic        sh0;
  logic [30:0] a_sh [3];
  logic [31:0] sp_mag [3];
  logic [2:0]  sp_neg;
  logic [31:0] s_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [32:0] nr;
      nr      = -r_r[i];
      rneg[i] = r_r[i][32];
      ar[i]   = rneg[i] ? nr[31:0] : r_r[i][31:0];
      sp_neg[i] = spin_r[i][31];
      sp_mag[i] = sp_neg[i] ? 32'(-spin_r[i]) : 32'(spin_r[i]);
    end
    sh0 = ar[0][31] | ar[1][31] | ar[2][31];
    for (int i = 0; i < 3; i++) begin
      a_sh[i] = sh0 ? ar[i][31:1] : ar[i][30:0];
    end
    s_mag = magnus_coeff_r[31] ? 32'(-magnus_coeff_r) : 32'(magnus_coeff_r);
  end

  // ---------------- t1/t2: sum of squares ----------------
  logic [61:0] sq_r [3];
  logic [63:0] sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 62'(a_sh[i]) * 62'(a_sh[i]);
      end
      sum_r <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
    end
  end

  // t2 -> t34: speed root
  logic [31:0] root;
  pad_sqrt u_sqrt (.clk, .en, .n_in(sum_r), .root(root));

  logic        sh34;
  logic [95:0] ar37_pk;
  logic [2:0]  rneg40;

  pad_dly #(.WIDTH(1),  .DEPTH(34)) u_dsh  (.clk, .en, .d(sh0), .q(sh34));
  pad_dly #(.WIDTH(96), .DEPTH(37)) u_dar  (.clk, .en, .d({ar[2], ar[1], ar[0]}), .q(ar37_pk));
  pad_dly #(.WIDTH(3),  .DEPTH(40)) u_dneg (.clk, .en, .d(rneg), .q(rneg40));

  // ---------------- t0 -> t7: Magnus term ----------------
  pad_pkg::mag_t pa_p [3];
  pad_pkg::mag_t pb_p [3];
  logic [2:0]    pa_c, pb_c;
  logic [5:0]    csgn0, csgn3;

  for (genvar i = 0; i < 3; i++) begin : g_cross
    assign csgn0[i]   = sp_neg[CA_S[i]] ^ rneg[CA_R[i]];
    assign csgn0[i+3] = sp_neg[CB_S[i]] ^ rneg[CB_R[i]];
    pad_mulq #(.FRAC_BITS(FRAC_BITS)) u_pa (
      .clk, .en, .a(64'(sp_mag[CA_S[i]])), .b(64'(ar[CA_R[i]])), .p(pa_p[i]), .clip(pa_c[i]));
    pad_mulq #(.FRAC_BITS(FRAC_BITS)) u_pb (
      .clk, .en, .a(64'(sp_mag[CB_S[i]])), .b(64'(ar[CB_R[i]])), .p(pb_p[i]), .clip(pb_c[i]));
  end

  pad_dly #(.WIDTH(6), .DEPTH(3)) u_dcs (.clk, .en, .d(csgn0), .q(csgn3));

  pad_pkg::mag_t cr_mag_r [3];
  logic [2:0]    cr_neg_r;
  logic          fl4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] diff;
      logic               dfl;
      dfl = 1'b0;
      for (int i = 0; i < 3; i++) begin
        diff        = smag(pa_p[i], csgn3[i]) - smag(pb_p[i], csgn3[i+3]);
        dfl         = dfl | ovr(diff);
        cr_mag_r[i] <= absm(clipv(diff));
        cr_neg_r[i] <= diff < 0;
      end
      fl4_r <= dfl | (|pa_c) | (|pb_c);
    end
  end

  pad_pkg::mag_t mg_p [3];
  logic [2:0]    mg_c;
  logic [3:0]    mgs7;

  for (genvar i = 0; i < 3; i++) begin : g_mag
    pad_mulq #(.FRAC_BITS(FRAC_BITS)) u_mg (
      .clk, .en, .a(64'(s_mag)), .b(64'(cr_mag_r[i])), .p(mg_p[i]), .clip(mg_c[i]));
  end

  pad_dly #(.WIDTH(4), .DEPTH(3)) u_dmgs (
    .clk, .en, .d({fl4_r, cr_neg_r ^ {3{magnus_coeff_r[31]}}}), .q(mgs7));

  logic [192:0] mg7_pk, mg40_pk;
  assign mg7_pk = {mgs7[3] | (|mg_c), smag(mg_p[2], mgs7[2]), smag(mg_p[1], mgs7[1]),
                   smag(mg_p[0], mgs7[0])};

  pad_dly #(.WIDTH(193), .DEPTH(33)) u_dmg (.clk, .en, .d(mg7_pk), .q(mg40_pk));

  // ---------------- t34 -> t40: drag ----------------
  pad_pkg::mag_t km_p;
  logic          km_c, km_c40;
  logic [32:0]   speed;

  assign speed = 33'(root) << sh34;

  pad_mulq #(.FRAC_BITS(FRAC_BITS)) u_km (
    .clk, .en, .a(64'(k_half)), .b(64'(speed)), .p(km_p), .clip(km_c));
  pad_dly #(.WIDTH(1), .DEPTH(3)) u_dkm (.clk, .en, .d(km_c), .q(km_c40));

  pad_pkg::mag_t d_p [3];
  logic [2:0]    d_c;

  for (genvar i = 0; i < 3; i++) begin : g_drag
    pad_mulq #(.FRAC_BITS(FRAC_BITS)) u_d (
      .clk, .en, .a(64'(km_p)), .b(64'(ar37_pk[32*i +: 32])), .p(d_p[i]), .clip(d_c[i]));
  end

  // ---------------- t41: force sum ----------------
  logic signed [63:0] force_r [3];
  logic               fl41_r;

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] dd, f;
      logic               ffl;
      ffl = 1'b0;
      for (int i = 0; i < 3; i++) begin
        dd = smag(d_p[i], ~rneg40[i]);
        f  = dd + signed'(mg40_pk[64*i +: 64]);
        if (i == 2) f = f - smag(grav_p, 1'b0);
        ffl = ffl | ovr(f);
        force_r[i] <= clipv(f);
      end
      fl41_r <= ffl | mg40_pk[192] | km_c40 | (|d_c) | static_fl;
    end
  end

  // ---------------- t42: divider setup ----------------
  logic [63:0] num_r [3];
  logic [2:0]  neg42_r, ovf42_r;
  logic        fl42_r;
  logic [63:0] mass_lim;

  assign mass_lim = 64'(mass_eff) << (32 - FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      pad_pkg::mag_t m;
      for (int i = 0; i < 3; i++) begin
        m = absm(force_r[i]);
        neg42_r[i] <= force_r[i] < 0;
        ovf42_r[i] <= 64'(m) >= mass_lim;
        num_r[i]   <= 64'(m) << FRAC_BITS;
      end
      fl42_r <= fl41_r;
    end
  end

  // t42 -> t58: quotient = |force| * 2^FRAC_BITS / mass
  logic [31:0] quo [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    pad_div u_div (.clk, .en, .num(num_r[i]), .den(mass_eff), .quo(quo[i]));
  end

  logic [6:0] side58;
  pad_dly #(.WIDTH(7), .DEPTH(16)) u_dside (
    .clk, .en, .d({fl42_r, ovf42_r, neg42_r}), .q(side58));

  // ---------------- t59: final clip, output register ----------------
  logic signed [31:0] acc_r [3];
  logic               sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      logic [32:0] a;
      logic [32:0] na;
      logic        cfl;
      cfl = side58[6];
      for (int i = 0; i < 3; i++) begin
        a = side58[3+i] ? 33'h1_0000_0000 : {1'b0, quo[i]};
        if (side58[i]) begin
          if (a > 33'h0_8000_0000) begin
            cfl = 1'b1;
            a   = 33'h0_8000_0000;
          end
          na = -a;
          acc_r[i] <= signed'(na[31:0]);
        end else begin
          if (a > 33'h0_7FFF_FFFF) begin
            cfl = 1'b1;
            a   = 33'h0_7FFF_FFFF;
          end
          acc_r[i] <= signed'(a[31:0]);
        end
      end
      sat_r <= cfl;
    end
  end

  assign out_ch.valid     = vld_r[LAT-1];
  assign out_ch.acc_x     = acc_r[0];
  assign out_ch.acc_y     = acc_r[1];
  assign out_ch.acc_z     = acc_r[2];
  assign out_ch.saturated = sat_r;

endmodule
